// ===== sv/lap_pkg.sv =====
package lap_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int MIN_DIM    = 3;
    localparam int PIX_W      = 8;
    localparam int POS_W      = 11;
    localparam int DIM_W      = 12;
    localparam int LINE_W     = 2 * PIX_W;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int SUM_W      = PIX_W + 4;
    localparam int CFG_IDX_W  = 1;

    localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(640);
    localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(480);
    localparam logic [DIM_W-1:0] DIM_LOW    = DIM_W'(MIN_DIM);
    localparam logic [DIM_W-1:0] WIDTH_HIGH = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] HEIGHT_HIGH = DIM_W'(MAX_HEIGHT);
    localparam logic [PIX_W-1:0] LEVEL_MAX  = {PIX_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_reg_idx;

    typedef logic [PIX_W-1:0] t_pix;

    typedef struct packed {
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
    } t_pos;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } t_dims;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] res;
        if (v < DIM_LOW) begin
            res = DIM_LOW;
        end else if (v > hi) begin
            res = hi;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

// ===== sv/lap_if.sv =====
interface lap_pix_if;
    import lap_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] blue_level;
    modport source (output valid, output blue_level, input ready);
    modport sink   (input valid, input blue_level, output ready);
endinterface

interface lap_res_if;
    import lap_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] edge_level;
    logic [POS_W-1:0] center_column;
    logic [POS_W-1:0] center_row;
    logic             frame_done;
    modport source (output valid, output edge_level, output center_column,
                    output center_row, output frame_done, input ready);
    modport sink   (input valid, input edge_level, input center_column,
                    input center_row, input frame_done, output ready);
endinterface

interface lap_cfg_if;
    import lap_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DIM_W-1:0]     data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/lap_ram.sv =====
module lap_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/lap_pos.sv =====
module lap_pos (
    input  logic           i_clk,
    input  logic           i_rst_n,
    lap_cfg_if.sink        i_cfg,
    input  logic           i_adv,
    output lap_pkg::t_pos  o_pos,
    output lap_pkg::t_dims o_dims
);
    import lap_pkg::*;

    logic [DIM_W-1:0] r_image_width,  n_image_width;
    logic [DIM_W-1:0] r_image_height, n_image_height;
    logic [POS_W-1:0] r_col, n_col;
    logic [POS_W-1:0] r_row, n_row;
    logic [DIM_W-1:0] width_eff;
    logic [DIM_W-1:0] height_eff;
    logic [DIM_W-1:0] col_inc;
    logic [DIM_W-1:0] row_inc;

    assign i_cfg.ready = 1'b1;

    assign width_eff  = clamp_dim(r_image_width, WIDTH_HIGH);
    assign height_eff = clamp_dim(r_image_height, HEIGHT_HIGH);
    assign col_inc    = {1'b0, r_col} + DIM_W'(1);
    assign row_inc    = {1'b0, r_row} + DIM_W'(1);

    always_comb begin
        n_image_width  = r_image_width;
        n_image_height = r_image_height;
        if (i_cfg.valid) begin
            unique case (t_reg_idx'(i_cfg.index))
                REG_IMAGE_WIDTH:  n_image_width  = i_cfg.data;
                REG_IMAGE_HEIGHT: n_image_height = i_cfg.data;
            endcase
        end
    end

    // wrap column at line end, row at frame end
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_adv) begin
            if (col_inc >= width_eff) begin
                n_col = '0;
                n_row = (row_inc >= height_eff) ? '0 : row_inc[POS_W-1:0];
            end else begin
                n_col = col_inc[POS_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= WIDTH_RST;
            r_image_height <= HEIGHT_RST;
            r_col          <= '0;
            r_row          <= '0;
        end else begin
            r_image_width  <= n_image_width;
            r_image_height <= n_image_height;
            r_col          <= n_col;
            r_row          <= n_row;
        end
    end

    assign o_pos.col     = r_col;
    assign o_pos.row     = r_row;
    assign o_dims.width  = width_eff;
    assign o_dims.height = height_eff;

endmodule

// ===== sv/lap_window.sv =====
module lap_window (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  lap_pkg::t_pix i_top,
    input  lap_pkg::t_pix i_mid,
    input  lap_pkg::t_pix i_bot,
    output lap_pkg::t_pix o_level
);
    import lap_pkg::*;

    // only the taps the kernel reads are kept: newest column of each line
    // plus the column before it on the middle line
    t_pix r_up, r_left, r_center, r_down;
    logic [SUM_W-1:0] sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up     <= '0;
            r_left   <= '0;
            r_center <= '0;
            r_down   <= '0;
        end else if (i_adv) begin
            r_up     <= i_top;
            r_left   <= r_center;
            r_center <= i_mid;
            r_down   <= i_bot;
        end
    end

    // after the shift the centre is the old newest middle tap, right is i_mid
    assign sum = SUM_W'(r_up) + SUM_W'(r_left) + SUM_W'(i_mid) + SUM_W'(r_down)
               - (SUM_W'(r_center) << 2);

    always_comb begin
        priority if (sum[SUM_W-1]) begin
            o_level = '0;
        end else if (sum > SUM_W'(LEVEL_MAX)) begin
            o_level = LEVEL_MAX;
        end else begin
            o_level = sum[PIX_W-1:0];
        end
    end

endmodule

// ===== sv/laplacian_3x3_edge_filter_core.sv =====
// channel   | port  | beat carries
// ----------+-------+------------------------------------------------------
// pixel in  | i_pix | blue_level
// result    | o_res | edge_level, center_column, center_row, frame_done
// config    | i_cfg | index (0 image_width, 1 image_height), data
//
// One pixel per clock while results are taken; a result passes the input
// stage (with line-store read), then the output register.
// The line store is one 2048 x 16 RAM, read at pixel accept and written back
// when the pixel leaves the input stage.
// Synchronous active-low reset clears counters, window taps and valids; the
// config registers return to 640 x 480. Line-store contents are not cleared.
// A stalled result holds the output register; the input stage keeps taking
// pixels that give no result.
module laplacian_3x3_edge_filter_core (
    input  logic     i_clk,
    input  logic     i_rst_n,
    lap_pix_if.sink  i_pix,
    lap_res_if.source o_res,
    lap_cfg_if.sink  i_cfg
);
    import lap_pkg::*;

    t_pos             pos;
    t_dims            dims;
    logic             in_fire;
    logic             in_ready;
    logic [LINE_W-1:0] line_rd;

    logic             r_s1_valid, n_s1_valid;
    t_pix             r_s1_blue;
    logic [POS_W-1:0] r_s1_col;
    logic [POS_W-1:0] r_s1_row;
    logic             s1_produce;
    logic             s1_last;
    logic             s1_adv;
    logic [DIM_W-1:0] s1_col_ext;
    logic [DIM_W-1:0] s1_row_ext;
    t_pix             level;

    logic             r_out_valid, n_out_valid;
    t_pix             r_out_level;
    logic [POS_W-1:0] r_out_col;
    logic [POS_W-1:0] r_out_row;
    logic             r_out_done;
    logic             out_free;

    assign in_fire     = i_pix.valid && in_ready;
    assign i_pix.ready = in_ready;

    lap_pos u_pos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .i_adv   (in_fire),
        .o_pos   (pos),
        .o_dims  (dims)
    );

    // entry holds {line r-2, line r-1}; write back shifts the lines down
    lap_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_col[ADDR_W-1:0]),
        .i_wdata ({line_rd[PIX_W-1:0], r_s1_blue}),
        .i_re    (in_fire),
        .i_raddr (pos.col[ADDR_W-1:0]),
        .o_rdata (line_rd)
    );

    lap_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (s1_adv),
        .i_top   (line_rd[LINE_W-1:PIX_W]),
        .i_mid   (line_rd[PIX_W-1:0]),
        .i_bot   (r_s1_blue),
        .o_level (level)
    );

    assign s1_col_ext = {1'b0, r_s1_col};
    assign s1_row_ext = {1'b0, r_s1_row};
    assign s1_produce = (s1_col_ext >= DIM_W'(2)) && (s1_row_ext >= DIM_W'(2))
                     && (s1_col_ext < dims.width) && (s1_row_ext < dims.height);
    assign s1_last    = (s1_col_ext + DIM_W'(1) == dims.width)
                     && (s1_row_ext + DIM_W'(1) == dims.height);

    assign out_free = !r_out_valid || o_res.ready;
    assign s1_adv   = r_s1_valid && (!s1_produce || out_free);
    assign in_ready = !r_s1_valid || s1_adv;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (in_fire) begin
            n_s1_valid = 1'b1;
        end else if (s1_adv) begin
            n_s1_valid = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (s1_adv && s1_produce) begin
            n_out_valid = 1'b1;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_blue <= i_pix.blue_level;
            r_s1_col  <= pos.col;
            r_s1_row  <= pos.row;
        end
        if (s1_adv && s1_produce) begin
            r_out_level <= level;
            r_out_col   <= r_s1_col - POS_W'(1);
            r_out_row   <= r_s1_row - POS_W'(1);
            r_out_done  <= s1_last;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.edge_level    = r_out_level;
    assign o_res.center_column = r_out_col;
    assign o_res.center_row    = r_out_row;
    assign o_res.frame_done    = r_out_done;

    a_center_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_col >= POS_W'(1) && r_out_row >= POS_W'(1)))
        else $error("result centre on the frame border");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> (r_s1_valid && $stable(r_s1_col)
                                     && $stable(r_s1_row)))
        else $error("stalled input stage lost its pixel");

    a_s1_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_s1_valid)
        else $error("accepted pixel did not reach the input stage");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(s1_adv && s1_produce))
        else $error("result raised without a producing pixel");

endmodule
